[hw/rtl/bbp_pkg.sv]
// Shared types, codes and constants of the bimodal branch predictor.
package bbp_pkg;

   localparam int TABLE_ENTRIES_DEF = 1024;

   localparam int PC_W    = 32;
   localparam int WORD_W  = PC_W - 2;
   localparam int CNT_W   = 32;
   localparam int ENTRY_W = 2;
   localparam int MODE_W  = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_MODE = REG_IDX_W'(0);

   localparam logic [MODE_W-1:0] MODE_STATIC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ONE_BIT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TWO_BIT = 2'd2;

   localparam logic CMD_PREDICT = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   localparam logic [ENTRY_W-1:0] TAKEN_THRESHOLD = 2'd2;
   localparam logic [ENTRY_W-1:0] COUNTER_MAX     = 2'd3;

   typedef struct packed {
      logic            cmd;
      logic [PC_W-1:0] pc;
      logic            taken;
      logic            was_correct;
   } req_type;

   typedef struct packed {
      logic             prediction;
      logic [CNT_W-1:0] branch_total;
      logic [CNT_W-1:0] correct_total;
   } rsp_type;

endpackage

[hw/rtl/bbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/bbp_index.sv]
// Table index unit: word address modulo the table size.
module bbp_index #(
   parameter int ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bbp_pkg::WORD_W-1:0] word,
   output logic                       done,
   output logic [$clog2(ENTRIES)-1:0] idx
);
   import bbp_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   generate
      if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
         logic             done_ff;
         logic [IDX_W-1:0] idx_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               idx_ff <= word[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign idx  = idx_ff;
      end else begin : g_recip
         // Reciprocal multiply: the quotient estimate is low by at most one,
         // so one compare and subtract finishes the remainder. Three steps.
         localparam logic [WORD_W-1:0] RECIP_L = WORD_W'((64'd1 << WORD_W) / ENTRIES);
         localparam logic [IDX_W:0]    MOD_L   = (IDX_W + 1)'(ENTRIES);

         logic [2*WORD_W-1:0] prod;
         logic                v1_ff, v2_ff, done_ff;
         logic [IDX_W:0]      word_ff;
         logic [IDX_W:0]      quot_ff;
         logic [IDX_W:0]      rem_ff;
         logic [IDX_W-1:0]    idx_ff;

         assign prod = (2*WORD_W)'(word) * (2*WORD_W)'(RECIP_L);

         always_ff @(posedge clock) begin
            if (reset) begin
               v1_ff   <= 1'b0;
               v2_ff   <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               v1_ff   <= start;
               v2_ff   <= v1_ff;
               done_ff <= v2_ff;
            end
         end

         // Remainder below twice the table size, so the low bits are enough.
         always_ff @(posedge clock) begin
            if (start) begin
               word_ff <= word[IDX_W:0];
               quot_ff <= prod[WORD_W+IDX_W:WORD_W];
            end
            rem_ff <= word_ff - quot_ff * MOD_L;
            idx_ff <= (rem_ff >= MOD_L) ? IDX_W'(rem_ff - MOD_L) : rem_ff[IDX_W-1:0];
         end

         assign done = done_ff;
         assign idx  = idx_ff;
      end
   endgenerate

endmodule

[hw/rtl/bimodal_branch_predictor_core.sv]
// Flow: the index unit (a bit slice for a power-of-two table, otherwise a
//   three-step reciprocal remainder), then the table read, then the response register.
// Throughput: one transaction in flight; the next is taken only after the index
//   step, one table read and one write-back per item, and a free response slot.
// Reset: synchronous; a clearing pass then zeroes every table entry,
//   with req_ready low; CSR writes are taken throughout.
module bimodal_branch_predictor_core #(
   parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bbp_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bbp_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bbp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bbp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bbp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bbp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_INDEX = 2'd2;
   localparam logic [1:0] S_READ  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_addr_ff, clr_addr_in;
   req_type           item_ff, item_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  right_ff, right_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                 req_take;
   logic                 idx_done;
   logic [IDX_W-1:0]     idx_out;
   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
   logic                 commit;
   logic                 pred;
   logic [ENTRY_W-1:0]   trained;
   logic                 train_en;
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_reg;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;

   bbp_index #(
      .ENTRIES(TABLE_ENTRIES)
   ) u_index (
      .clock(clock),
      .reset(reset),
      .start(req_take),
      .word (req_payload.pc[PC_W-1:2]),
      .done (idx_done),
      .idx  (idx_out)
   );

   bbp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(idx_out),
      .rdata(ram_rdata)
   );

   // One item in flight: write-back lands before the next read is issued.
   assign ram_re = (state_ff == S_INDEX) && idx_done;
   assign commit = (state_ff == S_READ) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      pred     = 1'b0;
      trained  = ram_rdata;
      train_en = 1'b0;
      unique case (mode_ff)
         MODE_ONE_BIT: begin
            pred     = (ram_rdata != '0);
            trained  = {1'b0, item_ff.taken};
            train_en = 1'b1;
         end
         MODE_TWO_BIT: begin
            pred     = (ram_rdata >= TAKEN_THRESHOLD);
            train_en = 1'b1;
            if (item_ff.taken && ram_rdata != COUNTER_MAX) begin
               trained = ram_rdata + ENTRY_W'(1);
            end else if (!item_ff.taken && ram_rdata != '0) begin
               trained = ram_rdata - ENTRY_W'(1);
            end
         end
         default: begin
            pred     = 1'b0;
            train_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = commit && (item_ff.cmd == CMD_UPDATE) && train_en;
         ram_waddr = idx_ff;
         ram_wdata = trained;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      right_in     = right_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               item_in  = req_payload;
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            if (idx_done) begin
               idx_in   = idx_out;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (commit) begin
               if (item_ff.cmd == CMD_UPDATE) begin
                  total_in = total_ff + CNT_W'(1);
                  if (item_ff.was_correct) begin
                     right_in = right_ff + CNT_W'(1);
                  end
               end
               rsp_in.prediction    = (item_ff.cmd == CMD_PREDICT) ? pred : 1'b0;
               rsp_in.branch_total  = total_in;
               rsp_in.correct_total = right_in;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // CSR decode on the word index of the address
   assign csr_reg    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign mode_in    = (csr_wr && csr_reg == REG_MODE) ? csr_pwdata[MODE_W-1:0] : mode_ff;
   assign csr_prdata = (csr_reg == REG_MODE) ? CSR_DATA_W'(mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         mode_ff      <= MODE_STATIC;
         total_ff     <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         mode_ff      <= mode_in;
         total_ff     <= total_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/bbp_checker.sv]
// Port-level checks for the bimodal branch predictor, bound to the top level.
module bbp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bbp_pkg::rsp_type rsp_payload
);
   import bbp_pkg::*;

   // Table clearing follows every reset, so no transaction can be taken.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // One transaction in flight at a time.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while one is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response dropped or changed");

endmodule

bind bimodal_branch_predictor_core bbp_checker u_bbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_payload(rsp_payload)
);

[dv/tb_bimodal_branch_predictor_core.sv]
// Self-checking testbench for the bimodal branch predictor core.
module tb_bimodal_branch_predictor_core;
   import bbp_pkg::*;

   localparam int TBL = TABLE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_PER_PHASE = 120;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};

   typedef struct {
      logic [MODE_W-1:0] mode;
      req_type           item;
      bit                typed;
      rsp_type           want;
   } stim_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the predictor state
   logic [ENTRY_W-1:0] shadow_table [TBL];
   logic [CNT_W-1:0]   shadow_total = '0;
   logic [CNT_W-1:0]   shadow_right = '0;
   logic [MODE_W-1:0]  shadow_mode = MODE_STATIC;

   rsp_type     awaited_replies [$];
   rsp_type     head_reply;
   stim_row     directed_plan [$];
   logic [31:0] hot_pc [16];
   int          hot_bias [16];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;

   bimodal_branch_predictor_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 30);
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   // Lookup or train one branch against the shadow state; returns the reply.
   function automatic rsp_type bimodal_step(input req_type item);
      int unsigned        slot;
      logic [ENTRY_W-1:0] ent;
      rsp_type            r;
      slot = (item.pc >> 2) % TBL;
      ent = shadow_table[slot];
      r.prediction = 1'b0;
      if (item.cmd == CMD_PREDICT) begin
         if (shadow_mode == MODE_ONE_BIT) r.prediction = (ent != '0);
         else if (shadow_mode == MODE_TWO_BIT) r.prediction = (ent >= TAKEN_THRESHOLD);
      end else begin
         shadow_total = shadow_total + 1'b1;
         if (item.was_correct) shadow_right = shadow_right + 1'b1;
         if (shadow_mode == MODE_ONE_BIT) begin
            shadow_table[slot] = {1'b0, item.taken};
         end else if (shadow_mode == MODE_TWO_BIT) begin
            if (item.taken && ent != COUNTER_MAX) ent = ent + 1'b1;
            else if (!item.taken && ent != '0) ent = ent - 1'b1;
            shadow_table[slot] = ent;
         end
      end
      r.branch_total = shadow_total;
      r.correct_total = shadow_right;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_replies.size() == 0) begin
            flag_mismatch($sformatf("unexpected result %p", rsp_payload));
         end else begin
            head_reply = awaited_replies.pop_front();
            if (rsp_payload.prediction !== head_reply.prediction)
               flag_mismatch($sformatf("prediction expected %0d got %0d",
                  head_reply.prediction, rsp_payload.prediction));
            if (rsp_payload.branch_total !== head_reply.branch_total)
               flag_mismatch($sformatf("branch_total expected %0d got %0d",
                  head_reply.branch_total, rsp_payload.branch_total));
            if (rsp_payload.correct_total !== head_reply.correct_total)
               flag_mismatch($sformatf("correct_total expected %0d got %0d",
                  head_reply.correct_total, rsp_payload.correct_total));
         end
      end
   end

   task automatic csr_access(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= MODE_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Sender pauses until every pending reply has been checked.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] m);
      logic [CSR_DATA_W-1:0] readback;
      drain_replies();
      repeat (4) @(posedge clock);
      csr_access(1'b1, CSR_DATA_W'(m), readback);
      shadow_mode = m;
      csr_access(1'b0, '0, readback);
      if (readback !== CSR_DATA_W'(m))
         flag_mismatch($sformatf("mode readback expected %0d got %0h", m, readback));
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type r;
      if (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      r = bimodal_step(item);
      awaited_replies.push_back(typed ? want : r);
   endtask

   function automatic void add_row(input logic [MODE_W-1:0] m, input logic c,
                                   input logic [PC_W-1:0] pc, input logic tk, input logic ok,
                                   input int typed, input logic p,
                                   input logic [CNT_W-1:0] bt, input logic [CNT_W-1:0] ct);
      stim_row row;
      row.mode = m;
      row.item.cmd = c;
      row.item.pc = pc;
      row.item.taken = tk;
      row.item.was_correct = ok;
      row.typed = (typed != 0);
      row.want.prediction = p;
      row.want.branch_total = bt;
      row.want.correct_total = ct;
      directed_plan.push_back(row);
   endfunction

   function automatic req_type random_branch();
      req_type it;
      int      h;
      it.cmd = 1'($urandom_range(1));
      if ($urandom_range(99) < 75) begin
         // hot branches with a per-address bias, so the counters saturate both ways
         h = $urandom_range(15);
         it.pc = hot_pc[h] ^ 32'($urandom_range(3));
         it.taken = ($urandom_range(99) < hot_bias[h]);
      end else begin
         it.pc = $urandom;
         it.taken = 1'($urandom_range(1));
      end
      it.was_correct = 1'($urandom_range(1));
      return it;
   endfunction

   initial begin
      logic [MODE_W-1:0] phase_modes [7];
      rsp_type           none;
      none = '0;
      phase_modes = '{MODE_TWO_BIT, MODE_ONE_BIT, MODE_TWO_BIT, MODE_STATIC,
                      MODE_UNUSED, MODE_ONE_BIT, MODE_TWO_BIT};
      for (int i = 0; i < TBL; i++) shadow_table[i] = '0;
      for (int i = 0; i < 16; i++) begin
         hot_pc[i] = $urandom;
         hot_bias[i] = $urandom_range(100);
      end

      // static: lookups ignore taken/was_correct, updates only count
      add_row(MODE_STATIC, CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b0, 0, 0);
      add_row(MODE_STATIC, CMD_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, 0, 0);
      add_row(MODE_STATIC, CMD_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, 1, 1);
      add_row(MODE_STATIC, CMD_UPDATE,  32'h0000_0000, 1'b0, 1'b0, 1, 1'b0, 2, 1);
      add_row(MODE_STATIC, CMD_PREDICT, 32'h0000_0000, 1'b0, 1'b0, 1, 1'b0, 2, 1);
      // one-bit: entry mirrors last outcome; low pc bits and aliases share an entry
      add_row(MODE_ONE_BIT, CMD_UPDATE,  32'h0000_0004, 1'b1, 1'b0, 1, 1'b0, 3, 1);
      add_row(MODE_ONE_BIT, CMD_PREDICT, 32'h0000_0004, 1'b0, 1'b0, 1, 1'b1, 3, 1);
      add_row(MODE_ONE_BIT, CMD_PREDICT, 32'h0000_0007, 1'b0, 1'b0, 1, 1'b1, 3, 1);
      add_row(MODE_ONE_BIT, CMD_PREDICT, 32'h0000_1004, 1'b0, 1'b0, 0, 1'b0, 0, 0);
      add_row(MODE_ONE_BIT, CMD_UPDATE,  32'h0000_0004, 1'b0, 1'b1, 1, 1'b0, 4, 2);
      add_row(MODE_ONE_BIT, CMD_PREDICT, 32'h0000_0004, 1'b0, 1'b0, 1, 1'b0, 4, 2);
      // two-bit: climb, saturate high, step down, saturate low
      add_row(MODE_TWO_BIT, CMD_UPDATE,  32'h0000_0008, 1'b1, 1'b0, 1, 1'b0, 5, 2);
      add_row(MODE_TWO_BIT, CMD_PREDICT, 32'h0000_0008, 1'b0, 1'b0, 1, 1'b0, 5, 2);
      add_row(MODE_TWO_BIT, CMD_UPDATE,  32'h0000_0008, 1'b1, 1'b1, 1, 1'b0, 6, 3);
      add_row(MODE_TWO_BIT, CMD_PREDICT, 32'h0000_0008, 1'b0, 1'b0, 1, 1'b1, 6, 3);
      add_row(MODE_TWO_BIT, CMD_UPDATE,  32'h0000_0008, 1'b1, 1'b1, 1, 1'b0, 7, 4);
      add_row(MODE_TWO_BIT, CMD_UPDATE,  32'h0000_0008, 1'b1, 1'b1, 1, 1'b0, 8, 5);
      add_row(MODE_TWO_BIT, CMD_UPDATE,  32'h0000_0008, 1'b0, 1'b0, 1, 1'b0, 9, 5);
      add_row(MODE_TWO_BIT, CMD_PREDICT, 32'h0000_0008, 1'b0, 1'b0, 0, 1'b0, 0, 0);
      add_row(MODE_TWO_BIT, CMD_UPDATE,  32'hFFFF_FFFC, 1'b0, 1'b0, 0, 1'b0, 0, 0);
      // mode change keeps the table: a counter at 2 predicts taken in one-bit mode
      add_row(MODE_ONE_BIT, CMD_PREDICT, 32'h0000_0008, 1'b0, 1'b0, 1, 1'b1, 10, 5);
      add_row(MODE_ONE_BIT, CMD_UPDATE,  32'h0000_0008, 1'b1, 1'b1, 1, 1'b0, 11, 6);
      // unused mode acts as static but still counts
      add_row(MODE_UNUSED, CMD_UPDATE,  32'h0000_0008, 1'b0, 1'b1, 1, 1'b0, 12, 7);
      add_row(MODE_UNUSED, CMD_PREDICT, 32'h0000_0008, 1'b1, 1'b1, 1, 1'b0, 12, 7);
      add_row(MODE_TWO_BIT, CMD_PREDICT, 32'h0000_0008, 1'b0, 1'b0, 1, 1'b0, 12, 7);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_mode(MODE_STATIC);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].mode != shadow_mode) set_mode(directed_plan[i].mode);
         send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
      end

      for (int p = 0; p < 7; p++) begin
         set_mode(phase_modes[p]);
         steady = (p == 2);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (p == 1 && n == RANDOM_PER_PHASE / 2) drain_replies();
            send_item(random_branch(), 1'b0, none);
         end
         steady = 1'b0;
      end

      drain_replies();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bbp_pkg.sv
hw/rtl/bbp_ram.sv
hw/rtl/bbp_index.sv
hw/rtl/bimodal_branch_predictor_core.sv
hw/rtl/bbp_checker.sv
dv/tb_bimodal_branch_predictor_core.sv
